// ===== rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: widths, payload types, cell data types, count codes.
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_BITS  = 16;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(66);

  // square root of the discriminant magnitude
  localparam int SQW  = WORD_BITS + 1;
  localparam int RADW = 2 * SQW;
  localparam int SRW  = SQW + 2;

  // divider
  localparam int DENW = WORD_BITS + 1;
  localparam int NMW  = WORD_BITS + 2;
  localparam int QW   = NMW + FRAC_BITS;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_quad;
    logic signed [WORD_BITS-1:0] coef_lin;
    logic signed [WORD_BITS-1:0] coef_const;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]                  root_count;
    logic signed [WORD_BITS-1:0] root_first;
    logic signed [WORD_BITS-1:0] root_second;
    logic                        overflow;
  } qrs_out_t;

  typedef struct packed {
    logic [SRW-1:0]  rem;
    logic [SQW-1:0]  root;
    logic [RADW-1:0] rad;
  } sqrt_data_t;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QW-1:0]   num;
    logic [QW-1:0]   quo;
    logic [DENW-1:0] den;
  } div_data_t;

endpackage

// ===== rtl/qrs_sqrt_cell.sv =====
// One stage of the integer square root chain: resolves one root bit per cycle.
`timescale 1ns / 1ps
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic       clk,
  input  sqrt_data_t d_i,
  output sqrt_data_t d_o
);

  logic [SRW+1:0] r4;
  logic [SRW+1:0] trial;
  sqrt_data_t     d_nxt;
  sqrt_data_t     d_r;

  always_comb begin
    r4        = {d_i.rem, d_i.rad[RADW-1 -: 2]};
    trial     = (SRW+2)'({d_i.root, 2'b01});
    d_nxt.rad = {d_i.rad[RADW-3:0], 2'b00};
    if (r4 >= trial) begin
      d_nxt.rem  = SRW'(r4 - trial);
      d_nxt.root = {d_i.root[SQW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = SRW'(r4);
      d_nxt.root = {d_i.root[SQW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

// ===== rtl/qrs_div_cell.sv =====
// One stage of the restoring divider chain: resolves one quotient bit per cycle.
`timescale 1ns / 1ps
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic      clk,
  input  div_data_t d_i,
  output div_data_t d_o
);

  logic [DENW:0] r2;
  logic          fit;
  div_data_t     d_nxt;
  div_data_t     d_r;

  always_comb begin
    r2        = {d_i.rem, d_i.num[QW-1]};
    fit       = r2 >= {1'b0, d_i.den};
    d_nxt.num = {d_i.num[QW-2:0], 1'b0};
    d_nxt.quo = {d_i.quo[QW-2:0], fit};
    d_nxt.den = d_i.den;
    if (fit) begin
      d_nxt.rem = DENW'(r2 - {1'b0, d_i.den});
    end else begin
      d_nxt.rem = DENW'(r2);
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

// ===== rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: decode, discriminant, root and divider chains.
//
//  channel  ports                           handshake
//  input    start, busy, in_data            taken when start & !busy
//  result   out_valid, out_data             one-cycle strobe, no backpressure
//  config   cfg_valid, cfg_ready, cfg_data  written when cfg_valid & cfg_ready
//
// Fully pipelined: one item per clock, busy stays low.
// Each item passes through the 33-cell square root chain and the 50-cell divider chains,
// with registered stages before, between and after them.
// Reset (rst_n low, synchronous) clears all valid bits and loads the tolerance with 66.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qrs_in_t             in_data,
  output logic                out_valid,
  output qrs_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_BITS-1:0] cfg_data
);

  localparam int PW  = 2 * WORD_BITS;
  localparam int DVW = RADW + 1;
  localparam int NSW = NMW + 1;

  typedef enum logic [2:0] {
    K_NONE, K_INF, K_LIN0, K_LIN, K_DBL0, K_DBL, K_TWO
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 an;
    logic [WORD_BITS-1:0] am;
    logic                 bn;
    logic [WORD_BITS-1:0] bm;
    logic                 cn;
    logic [WORD_BITS-1:0] cm;
    logic                 cz;
  } sq_side_t;

  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
    logic  cz;
  } dv_side_t;

  typedef struct packed {
    logic                 neg;
    logic [WORD_BITS-1:0] mag;
    logic                 sat;
  } root_t;

  function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] x);
    return x[WORD_BITS-1] ? WORD_BITS'(-x) : x;
  endfunction

  function automatic root_t make_root(input logic sgn, input logic [QW-1:0] q);
    root_t          r;
    logic [QW-1:0]  lim;
    r.neg = sgn && (q != '0);
    lim   = r.neg ? (QW'(1) << (WORD_BITS-1)) : ((QW'(1) << (WORD_BITS-1)) - QW'(1));
    r.sat = q > lim;
    r.mag = r.sat ? lim[WORD_BITS-1:0] : q[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] enc(input root_t r);
    return r.neg ? WORD_BITS'(-r.mag) : r.mag;
  endfunction

  logic [TOL_BITS-1:0] tol_r;

  // stage 1: sign and magnitude, zero tests
  logic                 s1_vld_r;
  logic                 s1_an_r, s1_bn_r, s1_cn_r;
  logic [WORD_BITS-1:0] s1_am_r, s1_bm_r, s1_cm_r;
  logic                 s1_az_r, s1_bz_r, s1_cz_r;
  logic [WORD_BITS-1:0] am_nxt, bm_nxt, cm_nxt;

  // stage 2: products
  logic                 s2_vld_r;
  logic                 s2_an_r, s2_bn_r, s2_cn_r;
  logic [WORD_BITS-1:0] s2_am_r, s2_bm_r, s2_cm_r;
  logic                 s2_az_r, s2_bz_r, s2_cz_r;
  logic [PW-1:0]        s2_sq_r, s2_ac_r;

  // stage 3: signed discriminant
  logic                 s3_vld_r;
  logic                 s3_an_r, s3_bn_r, s3_cn_r;
  logic [WORD_BITS-1:0] s3_am_r, s3_bm_r, s3_cm_r;
  logic                 s3_az_r, s3_bz_r, s3_cz_r;
  logic [DVW-1:0]       s3_d_r;
  logic [DVW-1:0]       fac_nxt, d_nxt;

  // stage 4: magnitude, classification
  logic                 s4_vld_r;
  sq_side_t             s4_side_r;
  logic [RADW-1:0]      s4_rad_r;
  logic [RADW-1:0]      dmag_nxt;
  sq_side_t             side4_nxt;

  sqrt_data_t           sq_w [SQW+1];
  sq_side_t             sq_side_r [SQW];
  logic [SQW-1:0]       sq_vld_r;

  // stage 5: divider operands
  logic                 s5_vld_r;
  dv_side_t             s5_side_r;
  div_data_t            s5_d1_r, s5_d2_r;
  sq_side_t             sq_last;
  logic [NSW-1:0]       nb, v1, v2;
  logic [NMW-1:0]       m1, m2;
  logic [DENW-1:0]      den2a;
  div_data_t            d1_nxt, d2_nxt;
  dv_side_t             side5_nxt;
  logic                 nneg1;
  logic                 dneg1;

  div_data_t            dv1_w [QW+1];
  div_data_t            dv2_w [QW+1];
  dv_side_t             dv_side_r [QW];
  logic [QW-1:0]        dv_vld_r;

  // output stage
  logic                 out_vld_r;
  qrs_out_t             out_r;
  qrs_out_t             out_nxt;
  dv_side_t             dv_last;
  root_t                x1, x2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  always_comb begin
    am_nxt = mag_of(in_data.coef_quad);
    bm_nxt = mag_of(in_data.coef_lin);
    cm_nxt = mag_of(in_data.coef_const);
  end

  always_comb begin
    fac_nxt = DVW'({s2_ac_r, 2'b00});
    if (s2_an_r == s2_cn_r) begin
      d_nxt = DVW'(s2_sq_r) - fac_nxt;
    end else begin
      d_nxt = DVW'(s2_sq_r) + fac_nxt;
    end
  end

  always_comb begin
    dmag_nxt = s3_d_r[DVW-1] ? RADW'(-s3_d_r) : s3_d_r[RADW-1:0];
    side4_nxt.an = s3_an_r;
    side4_nxt.am = s3_am_r;
    side4_nxt.bn = s3_bn_r;
    side4_nxt.bm = s3_bm_r;
    side4_nxt.cn = s3_cn_r;
    side4_nxt.cm = s3_cm_r;
    side4_nxt.cz = s3_cz_r;
    if (s3_az_r) begin
      if (s3_bz_r) begin
        side4_nxt.kind = s3_cz_r ? K_INF : K_NONE;
      end else begin
        side4_nxt.kind = s3_cz_r ? K_LIN0 : K_LIN;
      end
    end else if (dmag_nxt <= RADW'({tol_r, {FRAC_BITS{1'b0}}})) begin
      side4_nxt.kind = s3_bz_r ? K_DBL0 : K_DBL;
    end else if (!s3_d_r[DVW-1]) begin
      side4_nxt.kind = K_TWO;
    end else begin
      side4_nxt.kind = K_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      sq_vld_r  <= '0;
      s5_vld_r  <= 1'b0;
      dv_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= start && !busy;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      sq_vld_r  <= {sq_vld_r[SQW-2:0], s4_vld_r};
      s5_vld_r  <= sq_vld_r[SQW-1];
      dv_vld_r  <= {dv_vld_r[QW-2:0], s5_vld_r};
      out_vld_r <= dv_vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_an_r <= in_data.coef_quad[WORD_BITS-1];
    s1_bn_r <= in_data.coef_lin[WORD_BITS-1];
    s1_cn_r <= in_data.coef_const[WORD_BITS-1];
    s1_am_r <= am_nxt;
    s1_bm_r <= bm_nxt;
    s1_cm_r <= cm_nxt;
    s1_az_r <= am_nxt <= WORD_BITS'(tol_r);
    s1_bz_r <= bm_nxt <= WORD_BITS'(tol_r);
    s1_cz_r <= cm_nxt <= WORD_BITS'(tol_r);

    s2_an_r <= s1_an_r;
    s2_bn_r <= s1_bn_r;
    s2_cn_r <= s1_cn_r;
    s2_am_r <= s1_am_r;
    s2_bm_r <= s1_bm_r;
    s2_cm_r <= s1_cm_r;
    s2_az_r <= s1_az_r;
    s2_bz_r <= s1_bz_r;
    s2_cz_r <= s1_cz_r;
    s2_sq_r <= PW'(s1_bm_r) * PW'(s1_bm_r);
    s2_ac_r <= PW'(s1_am_r) * PW'(s1_cm_r);

    s3_an_r <= s2_an_r;
    s3_bn_r <= s2_bn_r;
    s3_cn_r <= s2_cn_r;
    s3_am_r <= s2_am_r;
    s3_bm_r <= s2_bm_r;
    s3_cm_r <= s2_cm_r;
    s3_az_r <= s2_az_r;
    s3_bz_r <= s2_bz_r;
    s3_cz_r <= s2_cz_r;
    s3_d_r  <= d_nxt;

    s4_side_r <= side4_nxt;
    s4_rad_r  <= dmag_nxt;
  end

  assign sq_w[0].rem  = '0;
  assign sq_w[0].root = '0;
  assign sq_w[0].rad  = s4_rad_r;

  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk (clk),
      .d_i (sq_w[k]),
      .d_o (sq_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    sq_side_r[0] <= s4_side_r;
    for (int i = 1; i < SQW; i++) begin
      sq_side_r[i] <= sq_side_r[i-1];
    end
  end

  always_comb begin
    sq_last = sq_side_r[SQW-1];
    nb      = sq_last.bn ? NSW'(sq_last.bm) : NSW'(-NSW'(sq_last.bm));
    v1      = nb + NSW'(sq_w[SQW].root);
    v2      = nb - NSW'(sq_w[SQW].root);
    m1      = v1[NSW-1] ? NMW'(-v1) : v1[NMW-1:0];
    m2      = v2[NSW-1] ? NMW'(-v2) : v2[NMW-1:0];
    den2a   = {sq_last.am, 1'b0};

    d1_nxt.rem = '0;
    d1_nxt.quo = '0;
    d2_nxt.rem = '0;
    d2_nxt.quo = '0;
    d2_nxt.num = {m2, {FRAC_BITS{1'b0}}};
    d2_nxt.den = den2a;

    case (sq_last.kind)
      K_LIN: begin
        d1_nxt.num = {NMW'(sq_last.cm), {FRAC_BITS{1'b0}}};
        d1_nxt.den = DENW'(sq_last.bm);
        nneg1      = !sq_last.cn;
        dneg1      = sq_last.bn;
      end
      K_DBL: begin
        d1_nxt.num = {NMW'(sq_last.bm), {FRAC_BITS{1'b0}}};
        d1_nxt.den = den2a;
        nneg1      = !sq_last.bn;
        dneg1      = sq_last.an;
      end
      default: begin
        d1_nxt.num = {m1, {FRAC_BITS{1'b0}}};
        d1_nxt.den = den2a;
        nneg1      = v1[NSW-1];
        dneg1      = sq_last.an;
      end
    endcase

    side5_nxt.kind = sq_last.kind;
    side5_nxt.cz   = sq_last.cz;
    side5_nxt.neg1 = nneg1 ^ dneg1;
    side5_nxt.neg2 = v2[NSW-1] ^ sq_last.an;
  end

  always_ff @(posedge clk) begin
    s5_d1_r   <= d1_nxt;
    s5_d2_r   <= d2_nxt;
    s5_side_r <= side5_nxt;
  end

  assign dv1_w[0] = s5_d1_r;
  assign dv2_w[0] = s5_d2_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qrs_div_cell u_cell1 (
      .clk (clk),
      .d_i (dv1_w[k]),
      .d_o (dv1_w[k+1])
    );
    qrs_div_cell u_cell2 (
      .clk (clk),
      .d_i (dv2_w[k]),
      .d_o (dv2_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    dv_side_r[0] <= s5_side_r;
    for (int i = 1; i < QW; i++) begin
      dv_side_r[i] <= dv_side_r[i-1];
    end
  end

  always_comb begin
    dv_last = dv_side_r[QW-1];
    x1      = make_root(dv_last.neg1, dv1_w[QW].quo);
    x2      = make_root(dv_last.neg2, dv2_w[QW].quo);
    out_nxt = '0;
    case (dv_last.kind)
      K_INF: begin
        out_nxt.root_count = CNT_INF;
      end
      K_LIN0, K_DBL0: begin
        out_nxt.root_count = CNT_ONE;
      end
      K_LIN, K_DBL: begin
        out_nxt.root_count = CNT_ONE;
        out_nxt.root_first = enc(x1);
        out_nxt.overflow   = x1.sat;
      end
      K_TWO: begin
        if (dv_last.cz) begin
          if (x1.mag <= WORD_BITS'(tol_r)) begin
            x1 = '0;
          end else begin
            x2 = '0;
          end
        end
        out_nxt.root_count  = CNT_TWO;
        out_nxt.root_first  = enc(x1);
        out_nxt.root_second = enc(x2);
        out_nxt.overflow    = x1.sat || x2.sat;
      end
      default: begin
        out_nxt.root_count = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_count == CNT_NONE |->
      out_data.root_first == '0 && out_data.root_second == '0 && !out_data.overflow)
    else $error("no-root result carries data");

  a_inf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_count == CNT_INF |->
      out_data.root_first == '0 && out_data.root_second == '0 && !out_data.overflow)
    else $error("infinite-root result carries data");

  a_one_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_count == CNT_ONE |-> out_data.root_second == '0)
    else $error("single root result has a second root");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_vld_r, 88))
    else $error("result without matching item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule
